[hdl/dld_pkg.sv]
// Shared types and constants for the decimal long divider.
package dld_pkg;

	localparam int DIGIT_W = 4;
	localparam int DIV_W   = 31;
	// remainder*10 + digit never exceeds 35 bits
	localparam int ACC_W   = DIV_W + 4;
	localparam int CNT_W   = 4;
	localparam int ADDR_W  = 3;
	localparam int DATA_W  = 32;

	localparam logic [CNT_W-1:0] QDIGIT_MAX = CNT_W'(9);
	localparam logic [DIV_W-1:0] DIV_RESET  = DIV_W'(1);

	// register word index, taken from paddr[2]
	localparam logic REG_DIVISOR = 1'b0;

	typedef enum logic {
		S_IDLE,
		S_STEP
	} state_t;

	// controller to datapath
	typedef struct packed {
		logic load;   // fold a new digit into the accumulator
		logic sub;    // one compare-subtract step
		logic skip;   // retire the digit without a result
		logic emit;   // write the result beat and update the remainder
	} cmd_t;

	// datapath to controller
	typedef struct packed {
		logic div_zero;
		logic acc_ge;
		logic cnt_max;
		logic cnt_zero;
		logic last;
		logic started;
		logic out_free;
	} sts_t;

endpackage

[hdl/decimal_long_division.sv]
// Top level: decimal long division by a configured binary divisor.
//
//   channel   signals                                   direction
//   input     in_valid/in_ready, digit, last            in
//   output    out_valid/out_ready, quotient_digit,      out
//             final_res
//   config    psel/penable/pwrite/paddr/pwdata/prdata   in/out
//
// A digit is folded into the accumulator, then goes through compare-subtract
// steps on the single shared subtractor (at most nine), and is then retired.
// Reset clears the remainder and control at once; the divisor resets to 1.
// A result beat waits in the output register and the next digit is accepted
// meanwhile; a further result holds the controller until taken.
module decimal_long_division import dld_pkg::*; (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               in_valid,
	output logic               in_ready,
	input  logic [DIGIT_W-1:0] digit,
	input  logic               last,
	output logic               out_valid,
	input  logic               out_ready,
	output logic [DIGIT_W-1:0] quotient_digit,
	output logic               final_res,
	input  logic               psel,
	input  logic               penable,
	input  logic               pwrite,
	input  logic [ADDR_W-1:0]  paddr,
	input  logic [DATA_W-1:0]  pwdata,
	output logic [DATA_W-1:0]  prdata,
	output logic               pready
);

	logic [DIV_W-1:0] divisor_q;
	logic             reg_hit;
	cmd_t             cmd;
	sts_t             sts;

	assign pready  = 1'b1;
	assign reg_hit = (paddr[ADDR_W-1] == REG_DIVISOR);

	// divisor register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			divisor_q <= DIV_RESET;
		end else if (psel && penable && pwrite && pready && reg_hit) begin
			divisor_q <= pwdata[DIV_W-1:0];
		end
	end

	assign prdata = reg_hit ? {{(DATA_W-DIV_W){1'b0}}, divisor_q} : '0;

	dld_ctrl u_ctrl (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_valid (in_valid),
		.in_ready (in_ready),
		.sts      (sts),
		.cmd      (cmd)
	);

	dld_datapath u_dp (
		.clk            (clk),
		.arst_n         (arst_n),
		.divisor        (divisor_q),
		.digit          (digit),
		.last           (last),
		.cmd            (cmd),
		.sts            (sts),
		.out_valid      (out_valid),
		.out_ready      (out_ready),
		.quotient_digit (quotient_digit),
		.final_res      (final_res)
	);

endmodule

[hdl/dld_ctrl.sv]
// Controller: sequences load, compare-subtract steps and the result beat or a skip.
module dld_ctrl import dld_pkg::*; (
	input  logic   clk,
	input  logic   arst_n,
	input  logic   in_valid,
	output logic   in_ready,
	input  sts_t   sts,
	output cmd_t   cmd
);

	state_t state_q, state_d;

	// state register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	// next state and commands
	always_comb begin
		state_d  = state_q;
		cmd      = '0;
		in_ready = 1'b0;
		case (state_q)
			S_IDLE: begin
				in_ready = 1'b1;
				if (in_valid) begin
					cmd.load = 1'b1;
					state_d  = S_STEP;
				end
			end
			S_STEP: begin
				if (sts.div_zero && !sts.last) begin
					// zero divisor, not the last digit: nothing to report
					cmd.skip = 1'b1;
					state_d  = S_IDLE;
				end else if (!sts.div_zero && !sts.started && !sts.acc_ge &&
						!sts.last && sts.cnt_zero) begin
					// leading quotient zero suppressed
					cmd.skip = 1'b1;
					state_d  = S_IDLE;
				end else if (!sts.div_zero && sts.acc_ge && !sts.cnt_max) begin
					cmd.sub = 1'b1;
				end else if (sts.out_free) begin
					cmd.emit = 1'b1;
					state_d  = S_IDLE;
				end
			end
			default: begin
				state_d = S_IDLE;
			end
		endcase
	end

endmodule

[hdl/dld_datapath.sv]
// Datapath: accumulator, shared subtractor, remainder and output register.
module dld_datapath import dld_pkg::*; (
	input  logic               clk,
	input  logic               arst_n,
	input  logic [DIV_W-1:0]   divisor,
	input  logic [DIGIT_W-1:0] digit,
	input  logic               last,
	input  cmd_t               cmd,
	output sts_t               sts,
	output logic               out_valid,
	input  logic               out_ready,
	output logic [DIGIT_W-1:0] quotient_digit,
	output logic               final_res
);

	logic [ACC_W-1:0]   acc_q;
	logic [DIV_W-1:0]   rem_q;
	logic [CNT_W-1:0]   cnt_q;
	logic               last_q;
	logic               started_q;
	logic               out_valid_q;
	logic [DIGIT_W-1:0] qdigit_q;
	logic               final_q;

	logic [ACC_W-1:0]   div_ext;
	logic [ACC_W-1:0]   acc_new;
	logic               acc_ge;

	assign div_ext = {{(ACC_W-DIV_W){1'b0}}, divisor};
	// remainder*10 as (rem<<3) + (rem<<1), plus the digit
	assign acc_new = {1'b0, rem_q, 3'b000} + {3'b000, rem_q, 1'b0}
		+ {{(ACC_W-DIGIT_W){1'b0}}, digit};
	assign acc_ge  = acc_q >= div_ext;

	// accumulator and step count
	always_ff @(posedge clk) begin
		if (cmd.load) begin
			acc_q  <= acc_new;
			cnt_q  <= '0;
			last_q <= last;
		end else if (cmd.sub) begin
			acc_q <= acc_q - div_ext;
			cnt_q <= cnt_q + CNT_W'(1);
		end
	end

	// running remainder and started flag
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			rem_q     <= '0;
			started_q <= 1'b0;
		end else if (cmd.skip) begin
			rem_q <= (divisor == '0) ? '0 : acc_q[DIV_W-1:0];
		end else if (cmd.emit) begin
			rem_q     <= last_q ? '0 : acc_q[DIV_W-1:0];
			started_q <= !last_q;
		end
	end

	// result beat holds until taken
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (cmd.emit) begin
			out_valid_q <= 1'b1;
		end else if (out_ready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.emit) begin
			qdigit_q <= cnt_q;
			final_q  <= last_q;
		end
	end

	assign sts.div_zero = (divisor == '0);
	assign sts.acc_ge   = acc_ge;
	assign sts.cnt_max  = (cnt_q == QDIGIT_MAX);
	assign sts.cnt_zero = (cnt_q == '0);
	assign sts.last     = last_q;
	assign sts.started  = started_q;
	assign sts.out_free = !out_valid_q || out_ready;

	assign out_valid      = out_valid_q;
	assign quotient_digit = qdigit_q;
	assign final_res      = final_q;

endmodule

[hdl/dld_checker.sv]
// Port-level checks for the decimal long divider, bound to the top level.
module dld_checker import dld_pkg::*; (
	input logic               clk,
	input logic               arst_n,
	input logic               in_valid,
	input logic               in_ready,
	input logic               out_valid,
	input logic               out_ready,
	input logic [DIGIT_W-1:0] quotient_digit,
	input logic               final_res,
	input logic [DATA_W-1:0]  prdata
);

	// a stalled result beat holds its payload
	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !out_ready |=> out_valid && $stable(quotient_digit)
			&& $stable(final_res))
		else $error("result beat changed while stalled");

	// quotient digits are decimal
	a_qdigit: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid |-> quotient_digit <= DIGIT_W'(9))
		else $error("quotient digit above nine");

	// one digit at a time
	a_one_item: assert property (@(posedge clk) disable iff (!arst_n)
		in_valid && in_ready |=> !in_ready)
		else $error("digit accepted while busy");

	// no result can appear in the cycle right after a digit is taken
	a_latency: assert property (@(posedge clk) disable iff (!arst_n)
		in_valid && in_ready |=> !$rose(out_valid))
		else $error("result beat too early");

	// the divisor readback fits in 31 bits
	a_prdata: assert property (@(posedge clk) disable iff (!arst_n)
		prdata[DATA_W-1] == 1'b0)
		else $error("divisor readback out of range");

endmodule

bind decimal_long_division dld_checker u_dld_checker (.*);
